/* design/tts_pkg.sv */
`timescale 1ns / 1ps

package tts_pkg;

  typedef logic [1:0] op_t;
  localparam op_t OP_CREATE = 2'd0;
  localparam op_t OP_UPDATE = 2'd1;
  localparam op_t OP_SCHED  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t RES_OK    = 2'd0;
  localparam status_t RES_FULL  = 2'd1;
  localparam status_t RES_NONE  = 2'd2;
  localparam status_t RES_EMPTY = 2'd3;

  typedef logic [2:0] tstate_t;
  localparam tstate_t TS_RUNNING = 3'd1;
  localparam tstate_t TS_READY   = 3'd2;

  typedef logic [1:0] res_sel_t;
  localparam res_sel_t RSEL_ZERO = 2'd0;
  localparam res_sel_t RSEL_IDX  = 2'd1;
  localparam res_sel_t RSEL_SLOT = 2'd2;
  localparam res_sel_t RSEL_BEST = 2'd3;

  typedef struct packed {
    logic     load;
    logic     idx_clr;
    logic     idx_inc;
    logic     create_wr;
    logic     update_wr;
    logic     scan_rd;
    logic     cur_rd;
    logic     cur_fix;
    logic     pick_wr;
    logic     res_set;
    res_sel_t res_sel;
    status_t  res_status;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic idx_last;
    logic idx_free;
    logic upd_ok;
    logic have;
    logic cur_valid;
    logic out_free;
  } sts_t;

endpackage

/* design/tts_if.sv */
`timescale 1ns / 1ps

interface tts_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [5:0] slot;
  logic [7:0] priority_req;
  logic [7:0] ticks_value;
  logic [31:0] jiffies_value;
  logic [2:0] task_state;

  modport source (
    output valid, operation, slot, priority_req, ticks_value, jiffies_value, task_state,
    input  ready
  );
  modport sink (
    input  valid, operation, slot, priority_req, ticks_value, jiffies_value, task_state,
    output ready
  );
endinterface

interface tts_rsp_if;
  logic       valid;
  logic       ready;
  logic [5:0] chosen_slot;
  logic [1:0] status;

  modport source (
    output valid, chosen_slot, status,
    input  ready
  );
  modport sink (
    input  valid, chosen_slot, status,
    output ready
  );
endinterface

/* design/tts_ctrl.sv */
`timescale 1ns / 1ps

module tts_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  tts_pkg::sts_t sts,
  output tts_pkg::cmd_t cmd
);
  import tts_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_C_SCAN   = 4'd2;
  localparam logic [3:0] S_S_SCAN   = 4'd3;
  localparam logic [3:0] S_DRAIN    = 4'd4;
  localparam logic [3:0] S_DECIDE   = 4'd5;
  localparam logic [3:0] S_FIX      = 4'd6;
  localparam logic [3:0] S_PICK     = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.res_sel    = RSEL_ZERO;
    cmd.res_status = RES_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_CREATE: begin
            cmd.idx_clr = 1'b1;
            state_next  = S_C_SCAN;
          end
          OP_UPDATE: begin
            cmd.res_set = 1'b1;
            if (sts.upd_ok) begin
              cmd.update_wr  = 1'b1;
              cmd.res_sel    = RSEL_SLOT;
              cmd.res_status = RES_OK;
            end else begin
              cmd.res_sel    = RSEL_ZERO;
              cmd.res_status = RES_EMPTY;
            end
            state_next = S_FINISH;
          end
          OP_SCHED: begin
            cmd.idx_clr = 1'b1;
            state_next  = S_S_SCAN;
          end
          default: begin
            cmd.res_set = 1'b1;
            state_next  = S_FINISH;
          end
        endcase
      end
      S_C_SCAN: begin
        if (sts.idx_free) begin
          cmd.create_wr  = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_sel    = RSEL_IDX;
          state_next     = S_FINISH;
        end else if (sts.idx_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = RES_FULL;
          state_next     = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.idx_last) begin
          state_next = S_DRAIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts.have) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = RES_NONE;
          state_next     = S_FINISH;
        end else if (sts.cur_valid) begin
          cmd.cur_rd = 1'b1;
          state_next = S_FIX;
        end else begin
          state_next = S_PICK;
        end
      end
      S_FIX: begin
        cmd.cur_fix = 1'b1;
        state_next  = S_PICK;
      end
      S_PICK: begin
        cmd.pick_wr = 1'b1;
        cmd.res_set = 1'b1;
        cmd.res_sel = RSEL_BEST;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/tts_datapath.sv */
`timescale 1ns / 1ps

module tts_datapath #(
  parameter int TASK_SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  tts_pkg::cmd_t cmd,
  output tts_pkg::sts_t sts,
  input  logic [1:0]    operation,
  input  logic [5:0]    slot,
  input  logic [7:0]    priority_req,
  input  logic [7:0]    ticks_value,
  input  logic [31:0]   jiffies_value,
  input  logic [2:0]    task_state,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [5:0]    chosen_slot,
  output logic [1:0]    status
);
  import tts_pkg::*;

  localparam int SW = $clog2(TASK_SLOTS);

  op_t         op_r;
  logic [5:0]  slot_r;
  logic [7:0]  prio_r;
  logic [7:0]  ticks_r;
  logic [31:0] jif_r;
  tstate_t     state_r;

  logic [TASK_SLOTS-1:0] used;
  logic [SW-1:0]         idx;
  logic [SW-1:0]         idx_d;
  logic [SW:0]           current;
  logic                  have;
  logic [SW-1:0]         best_slot;
  logic [7:0]            best_ticks;
  logic [31:0]           best_jif;
  logic                  eval_pend;
  logic                  elig_d;

  tstate_t     mem_state [TASK_SLOTS];
  logic [7:0]  mem_ticks [TASK_SLOTS];
  logic [31:0] mem_jif   [TASK_SLOTS];
  logic [7:0]  mem_prio  [TASK_SLOTS];

  tstate_t     rd_state;
  logic [7:0]  rd_ticks;
  logic [31:0] rd_jif;
  logic [7:0]  rd_prio;
  logic [SW-1:0] rd_addr;

  logic [SW-1:0] wr_addr;
  logic          st_we;
  tstate_t       st_wd;
  logic          tk_we;
  logic [7:0]    tk_wd;
  logic          jf_we;
  logic [31:0]   jf_wd;
  logic          pr_we;

  logic [5:0]  res_slot;
  status_t     res_status;

  logic [SW-1:0] slot_idx;
  logic [SW-1:0] cur_idx;
  logic          upd_ok;
  logic          cur_valid;
  logic          better;
  logic          take;

  assign slot_idx  = SW'(slot_r);
  assign cur_idx   = current[SW-1:0];
  assign upd_ok    = (32'(slot_r) < 32'(TASK_SLOTS)) && used[slot_idx];
  assign cur_valid = (current < (SW+1)'(TASK_SLOTS)) && used[cur_idx];
  assign rd_addr   = cmd.cur_rd ? cur_idx : idx;

  assign better = !have || (best_ticks < rd_ticks) || (rd_jif < best_jif);
  assign take   = eval_pend && elig_d && (rd_state == TS_READY) && better;

  assign sts.op        = op_r;
  assign sts.idx_last  = (idx == SW'(TASK_SLOTS - 1));
  assign sts.idx_free  = !used[idx];
  assign sts.upd_ok    = upd_ok;
  assign sts.have      = have;
  assign sts.cur_valid = cur_valid;
  assign sts.out_free  = !out_valid || out_ready;

  always_comb begin
    wr_addr = idx;
    st_we   = 1'b0;
    st_wd   = TS_READY;
    tk_we   = 1'b0;
    tk_wd   = prio_r;
    jf_we   = 1'b0;
    jf_wd   = '0;
    pr_we   = 1'b0;
    priority if (cmd.create_wr) begin
      st_we = 1'b1;
      tk_we = 1'b1;
      jf_we = 1'b1;
      pr_we = 1'b1;
    end else if (cmd.update_wr) begin
      wr_addr = slot_idx;
      st_we   = 1'b1;
      st_wd   = state_r;
      tk_we   = 1'b1;
      tk_wd   = ticks_r;
      jf_we   = 1'b1;
      jf_wd   = jif_r;
    end else if (cmd.cur_fix) begin
      wr_addr = cur_idx;
      st_we   = (rd_state == TS_RUNNING);
      tk_we   = (rd_ticks == 8'd0);
      tk_wd   = rd_prio;
    end else if (cmd.pick_wr) begin
      wr_addr = best_slot;
      st_we   = 1'b1;
      st_wd   = TS_RUNNING;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      mem_state[wr_addr] <= st_wd;
    end
    if (tk_we) begin
      mem_ticks[wr_addr] <= tk_wd;
    end
    if (jf_we) begin
      mem_jif[wr_addr] <= jf_wd;
    end
    if (pr_we) begin
      mem_prio[wr_addr] <= prio_r;
    end
    rd_state <= mem_state[rd_addr];
    rd_ticks <= mem_ticks[rd_addr];
    rd_jif   <= mem_jif[rd_addr];
    rd_prio  <= mem_prio[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      current   <= (SW+1)'(TASK_SLOTS);
      have      <= 1'b0;
      eval_pend <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      eval_pend <= cmd.scan_rd;
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + SW'(1);
      end
      if (cmd.idx_clr) begin
        have <= 1'b0;
      end else if (take) begin
        have <= 1'b1;
      end
      if (cmd.create_wr) begin
        used[idx] <= 1'b1;
      end
      if (cmd.pick_wr) begin
        current <= {1'b0, best_slot};
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= operation;
      slot_r  <= slot;
      prio_r  <= priority_req;
      ticks_r <= ticks_value;
      jif_r   <= jiffies_value;
      state_r <= task_state;
    end
    idx_d  <= idx;
    elig_d <= used[idx] && ({1'b0, idx} != current);
    if (take) begin
      best_slot  <= idx_d;
      best_ticks <= rd_ticks;
      best_jif   <= rd_jif;
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      unique case (cmd.res_sel)
        RSEL_ZERO: res_slot <= 6'd0;
        RSEL_IDX:  res_slot <= 6'(idx);
        RSEL_SLOT: res_slot <= slot_r;
        RSEL_BEST: res_slot <= 6'(best_slot);
        default:   res_slot <= 6'd0;
      endcase
    end
    if (cmd.out_load) begin
      chosen_slot <= res_slot;
      status      <= res_status;
    end
  end

  a_current_range: assert property (@(posedge clk) disable iff (rst)
    current <= (SW+1)'(TASK_SLOTS))
    else $error("current slot out of range");

  a_pick_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.pick_wr |-> have && ({1'b0, best_slot} != current))
    else $error("pick without candidate or equal to current");

  a_create_free: assert property (@(posedge clk) disable iff (rst)
    cmd.create_wr |-> !used[idx])
    else $error("create into used slot");

  a_update_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.update_wr |-> upd_ok)
    else $error("update of empty slot");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwrites pending beat");

endmodule

/* design/task_table_ready_scheduler_top.sv */
// One item at a time; schedule walks the whole table in a one-slot-per-cycle scan.
// Create likewise walks the used bits from slot 0 until it finds an empty slot.
// A finished result waits in an output register while the next beat is accepted.
// Reset (rst, synchronous): all slots empty, current task is the boot task.
`timescale 1ns / 1ps

module task_table_ready_scheduler_top #(
  parameter int TASK_SLOTS = 64
) (
  input logic        clk,
  input logic        rst,
  tts_req_if.sink    req,
  tts_rsp_if.source  rsp
);
  import tts_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;
  logic [5:0] chosen_slot;
  logic [1:0] status;

  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tts_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (req.operation),
    .slot          (req.slot),
    .priority_req  (req.priority_req),
    .ticks_value   (req.ticks_value),
    .jiffies_value (req.jiffies_value),
    .task_state    (req.task_state),
    .out_valid     (out_valid),
    .out_ready     (rsp.ready),
    .chosen_slot   (chosen_slot),
    .status        (status)
  );

  assign req.ready       = in_ready;
  assign rsp.valid       = out_valid;
  assign rsp.chosen_slot = chosen_slot;
  assign rsp.status      = status;

endmodule
